[design/dtq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, constants and saturating arithmetic for the delta timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int TAG_BITS    = 16;
   localparam int MAX_OUT     = 16;
   localparam int DELTA_W     = 32;
   localparam int ADDR_W      = $clog2(NUM_ENTRIES);
   localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_INSERT = 2'd1,
      OP_CANCEL = 2'd2,
      OP_DRAIN  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_NOT_FOUND   = 2'd2,
      ST_NOTHING_DUE = 2'd3
   } status_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]       tag;
      logic signed [DELTA_W-1:0] delta;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic idle;
      logic accept;
      logic walk;
      logic emit;
      logic shift;
      logic resp;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic to_resp;
      logic walk_done;
      logic walk_to_emit;
      logic emit_last;
      logic shift_end;
      logic out_free;
   } sts_type;

   function automatic logic signed [DELTA_W-1:0] sat_fix(input logic signed [DELTA_W:0] s);
      logic signed [DELTA_W-1:0] r;
      if (s[DELTA_W] != s[DELTA_W-1]) begin
         r = s[DELTA_W] ? {1'b1, {(DELTA_W-1){1'b0}}} : {1'b0, {(DELTA_W-1){1'b1}}};
      end else begin
         r = s[DELTA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DELTA_W-1:0] sat_add(input logic signed [DELTA_W-1:0] a,
                                                         input logic signed [DELTA_W-1:0] b);
      logic signed [DELTA_W:0] s;
      s = {a[DELTA_W-1], a} + {b[DELTA_W-1], b};
      return sat_fix(s);
   endfunction

   function automatic logic signed [DELTA_W-1:0] sat_sub(input logic signed [DELTA_W-1:0] a,
                                                         input logic signed [DELTA_W-1:0] b);
      logic signed [DELTA_W:0] s;
      s = {a[DELTA_W-1], a} - {b[DELTA_W-1], b};
      return sat_fix(s);
   endfunction

endpackage

[design/dtq_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] handle_tag;
   logic signed [31:0] delay_ticks;

   modport source (output valid, req_type, handle_tag, delay_ticks, input ready);
   modport sink (input valid, req_type, handle_tag, delay_ticks, output ready);
endinterface

interface dtq_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] entry_tag;
   logic signed [31:0] entry_lateness;
   logic [1:0]  status;
   logic        soft_due;
   logic        last;

   modport source (output valid, entry_tag, entry_lateness, status, soft_due, last,
                   input ready);
   modport sink (input valid, entry_tag, entry_lateness, status, soft_due, last,
                 output ready);
endinterface

[design/dtq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[design/dtq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer for the list walk, drain emission and compaction phases.
// ----------------------------------------------------------------------------
module dtq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dtq_pkg::sts_type sts,
   output dtq_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_WALK  = 5'b00010,
      S_EMIT  = 5'b00100,
      S_SHIFT = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = sts.to_resp ? S_RESP : S_WALK;
         end
         S_WALK: begin
            if (sts.walk_done) state_in = sts.walk_to_emit ? S_EMIT : S_RESP;
         end
         S_EMIT: begin
            if (sts.out_free && sts.emit_last) state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (sts.shift_end) state_in = S_IDLE;
         end
         S_RESP: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign cmd.idle   = (state_ff == S_IDLE);
   assign cmd.accept = (state_ff == S_IDLE) && req_valid;
   assign cmd.walk   = (state_ff == S_WALK);
   assign cmd.emit   = (state_ff == S_EMIT);
   assign cmd.shift  = (state_ff == S_SHIFT);
   assign cmd.resp   = (state_ff == S_RESP);

endmodule

[design/dtq_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_dp
// Datapath: list RAM, walk index, per-request registers and output register.
// ----------------------------------------------------------------------------
module dtq_dp (
   input  logic             clock,
   input  logic             reset,
   input  dtq_pkg::cmd_type cmd,
   output dtq_pkg::sts_type sts,
   input  logic [1:0]       req_type,
   input  logic [15:0]      handle_tag,
   input  logic signed [31:0] delay_ticks,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [15:0]      rsp_tag,
   output logic signed [31:0] rsp_lateness,
   output logic [1:0]       rsp_status,
   output logic             rsp_soft_due,
   output logic             rsp_last
);

   localparam int AW = dtq_pkg::ADDR_W;
   localparam int CW = dtq_pkg::CNT_W;
   localparam int DW = dtq_pkg::DELTA_W;
   localparam int TW = dtq_pkg::TAG_BITS;

   logic [CW-1:0]          n_ff, n_in, idx_ff, idx_in, cnt_ff, cnt_in;
   dtq_pkg::op_type        op_ff, op_in;
   logic [TW-1:0]          tag_ff, tag_in;
   logic signed [DW-1:0]   t_ff, t_in, fold_ff, fold_in;
   dtq_pkg::entry_type     carry_ff, carry_in;
   logic                   hit_ff, hit_in, due_ff, due_in;
   dtq_pkg::status_type    stat_ff, stat_in;

   logic                   out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic                   out_due_ff, out_due_in;
   logic [15:0]            out_tag_ff, out_tag_in;
   logic signed [DW-1:0]   out_lat_ff, out_lat_in;
   dtq_pkg::status_type    out_stat_ff, out_stat_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   dtq_pkg::entry_type     wr_data, rd_data;
   logic                   at_end, out_free, load;
   logic signed [DW-1:0]   nd, d;

   dtq_ram #(.WIDTH($bits(dtq_pkg::entry_type)), .DEPTH(dtq_pkg::NUM_ENTRIES)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in[AW-1:0]),
      .rd_data (rd_data)
   );

   assign d        = rd_data.delta;
   assign at_end   = (idx_ff == n_ff);
   assign out_free = !out_valid_ff || rsp_ready;
   assign nd       = dtq_pkg::sat_sub(d, DW'(1));

   always_comb begin
      n_in = n_ff; idx_in = idx_ff; cnt_in = cnt_ff; op_in = op_ff; tag_in = tag_ff;
      t_in = t_ff; fold_in = fold_ff; carry_in = carry_ff; hit_in = hit_ff;
      due_in = due_ff; stat_in = stat_ff;
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = rd_data;
      load = 1'b0; out_tag_in = 16'd0; out_lat_in = '0; out_stat_in = dtq_pkg::ST_OK;
      out_due_in = 1'b0; out_last_in = 1'b1;
      sts = '0;
      sts.out_free     = out_free;
      sts.to_resp      = (dtq_pkg::op_type'(req_type) == dtq_pkg::OP_INSERT) &&
                         (int'(n_ff) >= dtq_pkg::NUM_ENTRIES);
      sts.emit_last    = (idx_ff + CW'(1) == cnt_ff);
      sts.shift_end    = (idx_ff >= n_ff);
      sts.walk_to_emit = (op_ff == dtq_pkg::OP_DRAIN) && (cnt_ff != '0);

      if (cmd.idle) begin
         idx_in = '0;
      end
      if (cmd.accept) begin
         op_in   = dtq_pkg::op_type'(req_type);
         tag_in  = TW'(handle_tag);
         t_in    = (delay_ticks[DW-1] || delay_ticks == '0) ? DW'(1) : delay_ticks;
         hit_in  = 1'b0;
         fold_in = '0;
         cnt_in  = '0;
         due_in  = 1'b0;
         stat_in = sts.to_resp ? dtq_pkg::ST_FULL : dtq_pkg::ST_OK;
      end

      if (cmd.walk) begin
         case (op_ff)
            dtq_pkg::OP_TICK: begin
               sts.walk_done = at_end || !nd[DW-1];
               if (!at_end) begin
                  wr_en   = 1'b1;
                  wr_data = '{tag: rd_data.tag, delta: nd};
                  if (nd[DW-1] || nd == '0) due_in = 1'b1;
                  idx_in  = idx_ff + CW'(1);
               end
            end
            dtq_pkg::OP_INSERT: begin
               sts.walk_done = at_end;
               idx_in = idx_ff + CW'(1);
               if (!hit_ff) begin
                  // The new entry goes in front of the first delta that reaches it.
                  if (at_end || d >= t_ff) begin
                     wr_en    = 1'b1;
                     wr_data  = '{tag: tag_ff, delta: t_ff};
                     carry_in = '{tag: rd_data.tag, delta: dtq_pkg::sat_sub(d, t_ff)};
                     hit_in   = 1'b1;
                  end else if (!d[DW-1] && d != '0) begin
                     t_in = t_ff - d;
                  end
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = carry_ff;
                  carry_in = rd_data;
               end
               if (at_end) n_in = n_ff + CW'(1);
            end
            dtq_pkg::OP_CANCEL: begin
               sts.walk_done = at_end;
               idx_in = idx_ff + CW'(1);
               if (at_end) begin
                  stat_in = hit_ff ? dtq_pkg::ST_OK : dtq_pkg::ST_NOT_FOUND;
                  if (hit_ff) n_in = n_ff - CW'(1);
               end else if (!hit_ff) begin
                  if (rd_data.tag == tag_ff) begin
                     hit_in  = 1'b1;
                     fold_in = (!d[DW-1] && d != '0) ? d : '0;
                  end
               end else begin
                  // Close the gap; only the first follower takes the folded delta.
                  wr_en   = 1'b1;
                  wr_addr = AW'(idx_ff - CW'(1));
                  wr_data = '{tag: rd_data.tag, delta: dtq_pkg::sat_add(d, fold_ff)};
                  fold_in = '0;
               end
            end
            default: begin
               if (!at_end && int'(idx_ff) < dtq_pkg::MAX_OUT && (d[DW-1] || d == '0)) begin
                  cnt_in = cnt_ff + CW'(1);
                  idx_in = idx_ff + CW'(1);
               end else begin
                  sts.walk_done = 1'b1;
                  idx_in = '0;
                  if (cnt_ff == '0) stat_in = dtq_pkg::ST_NOTHING_DUE;
               end
            end
         endcase
      end

      if (cmd.emit && out_free) begin
         load        = 1'b1;
         out_tag_in  = 16'(rd_data.tag);
         out_lat_in  = d;
         out_last_in = sts.emit_last;
         idx_in      = sts.emit_last ? cnt_ff : idx_ff + CW'(1);
      end

      if (cmd.shift) begin
         if (!sts.shift_end) begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff - cnt_ff);
            idx_in  = idx_ff + CW'(1);
         end else begin
            n_in = n_ff - cnt_ff;
         end
      end

      if (cmd.resp && out_free) begin
         load        = 1'b1;
         out_stat_in = stat_ff;
         out_due_in  = due_ff;
      end

      if (load) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff   <= cnt_in;
      op_ff    <= op_in;
      tag_ff   <= tag_in;
      t_ff     <= t_in;
      fold_ff  <= fold_in;
      carry_ff <= carry_in;
      hit_ff   <= hit_in;
      due_ff   <= due_in;
      stat_ff  <= stat_in;
      if (load) begin
         out_tag_ff  <= out_tag_in;
         out_lat_ff  <= out_lat_in;
         out_stat_ff <= out_stat_in;
         out_due_ff  <= out_due_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_tag      = out_tag_ff;
   assign rsp_lateness = out_lat_ff;
   assign rsp_status   = out_stat_ff;
   assign rsp_soft_due = out_due_ff;
   assign rsp_last     = out_last_ff;

endmodule

[design/delta_timer_queue.sv]
`timescale 1ns / 1ps
// A tick walks until the list ends or an entry's decremented delta is not negative;
// insert and cancel walk the whole list; an insert into a full list responds without a walk.
// Drain counts the due entries, emits one response per due entry, then compacts the list.
// Throughput is one request at a time, set by the one-entry-per-cycle walk over the RAM.
// Synchronous reset empties the list at once; the RAM contents are left as they are.
// ----------------------------------------------------------------------------
// delta_timer_queue
// Callout queue kept as an ordered delta list in a RAM, walked one entry a cycle.
// ----------------------------------------------------------------------------
module delta_timer_queue (
   input logic       clock,
   input logic       reset,
   dtq_req_if.sink   req_bus,
   dtq_rsp_if.source rsp_bus
);

   dtq_pkg::cmd_type cmd;
   dtq_pkg::sts_type sts;

   dtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dtq_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_type     (req_bus.req_type),
      .handle_tag   (req_bus.handle_tag),
      .delay_ticks  (req_bus.delay_ticks),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_tag      (rsp_bus.entry_tag),
      .rsp_lateness (rsp_bus.entry_lateness),
      .rsp_status   (rsp_bus.status),
      .rsp_soft_due (rsp_bus.soft_due),
      .rsp_last     (rsp_bus.last)
   );

endmodule

[design/dtq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks on the response channel of the delta timer queue.
// ----------------------------------------------------------------------------
module dtq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_tag,
   input logic signed [31:0] rsp_lateness,
   input logic [1:0]  rsp_status,
   input logic        rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tag) && $stable(rsp_lateness))
      else $error("stalled response changed");

   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == dtq_pkg::ST_OK)
      else $error("non-final response with error status");

   a_late: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lateness[31] || rsp_lateness == 32'sd0)
      else $error("positive lateness");

endmodule

bind delta_timer_queue dtq_checker u_dtq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_tag      (rsp_bus.entry_tag),
   .rsp_lateness (rsp_bus.entry_lateness),
   .rsp_status   (rsp_bus.status),
   .rsp_last     (rsp_bus.last)
);
